// ===== rtl/vdt_pkg.sv =====
`default_nettype none

package vdt_pkg;

    // Table geometry: the table is interleaved over a row of cells, entry
    // e lives in cell (e mod NUM_CELLS) at row (e / NUM_CELLS).
    localparam int TABLE_DEPTH = 1024;
    localparam int NUM_CELLS   = 8;
    localparam int CELL_ROWS   = TABLE_DEPTH / NUM_CELLS;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int CELL_W      = $clog2(NUM_CELLS);
    localparam int ROW_W       = IDX_W - CELL_W;
    localparam int ROWCNT_W    = ROW_W + 1;

    // Field widths.
    localparam int ID_W      = 16;
    localparam int COORD_W   = 32;
    localparam int TOL_W     = 31;
    localparam int S_TDATA_W = ID_W + 5 * COORD_W;
    localparam int M_TDATA_W = 16;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(839);

    // Configuration register indices.
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_MATCH_UV     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MATCH_NORMAL = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TOLERANCE    = 2'd2;

    // Request kinds carried in tuser.
    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    // One stored vertex; the vertex id sits in the lowest bits so that the
    // struct lines up with the slave tdata layout.
    typedef struct packed {
        logic [COORD_W-1:0] nz;
        logic [COORD_W-1:0] ny;
        logic [COORD_W-1:0] nx;
        logic [COORD_W-1:0] v;
        logic [COORD_W-1:0] u;
        logic [ID_W-1:0]    id;
    } entry_t;

    typedef struct packed {
        logic             match_uv;
        logic             match_normal;
        logic [TOL_W-1:0] tol;
    } cfg_t;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic              rd_en;
        logic [ROW_W-1:0]  rd_row;
        logic              rd_vld;
        logic              wr_en;
        logic [ROW_W-1:0]  wr_row;
        logic [CELL_W-1:0] wr_cell;
        logic [CNT_W-1:0]  count;
    } ctrl_t;

    // First-hit token passed from cell to cell.
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] index;
    } chain_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/vdt_cell.sv =====
`default_nettype none

module vdt_cell (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic [vdt_pkg::CELL_W-1:0] cell_idx,
    input  wire vdt_pkg::cfg_t              cfg,
    input  wire vdt_pkg::ctrl_t             ctrl,
    input  wire vdt_pkg::entry_t            query,
    input  wire vdt_pkg::chain_t            chain_in,
    output vdt_pkg::chain_t                 chain_out
);

    // True when |a - b| <= tol, with the difference taken exactly.
    function automatic logic close_enough(
        input logic [vdt_pkg::COORD_W-1:0] a,
        input logic [vdt_pkg::COORD_W-1:0] b,
        input logic [vdt_pkg::TOL_W-1:0]   tol
    );
        logic signed [vdt_pkg::COORD_W+1:0] d;
        logic signed [vdt_pkg::COORD_W+1:0] t;
        d = $signed({{2{a[vdt_pkg::COORD_W-1]}}, a}) - $signed({{2{b[vdt_pkg::COORD_W-1]}}, b});
        t = $signed({3'b000, tol});
        return (d <= t) && (d >= -t);
    endfunction

    vdt_pkg::entry_t                 mem [vdt_pkg::CELL_ROWS];
    vdt_pkg::entry_t                 rdata_reg;
    logic [vdt_pkg::ROW_W-1:0]       rd_row_reg;
    logic                            hit_reg;
    logic                            hit_next;
    logic [vdt_pkg::IDX_W-1:0]       hit_idx_reg;
    logic [vdt_pkg::IDX_W-1:0]       entry_idx;
    logic                            uv_ok;
    logic                            n_ok;

    // Local slice of the table: one write port for appends, one registered
    // read port for the scan.
    always_ff @(posedge aclk) begin
        if (ctrl.wr_en && (ctrl.wr_cell == cell_idx)) begin
            mem[ctrl.wr_row] <= query;
        end
        if (ctrl.rd_en) begin
            rdata_reg  <= mem[ctrl.rd_row];
            rd_row_reg <= ctrl.rd_row;
        end
    end

    // Compare the entry just read against the request.
    always_comb begin
        entry_idx = {rd_row_reg, cell_idx};
        uv_ok = close_enough(query.u, rdata_reg.u, cfg.tol) &&
                close_enough(query.v, rdata_reg.v, cfg.tol);
        n_ok  = close_enough(query.nx, rdata_reg.nx, cfg.tol) &&
                close_enough(query.ny, rdata_reg.ny, cfg.tol) &&
                close_enough(query.nz, rdata_reg.nz, cfg.tol);
        hit_next = ctrl.rd_vld &&
                   ({1'b0, entry_idx} < ctrl.count) &&
                   (rdata_reg.id == query.id) &&
                   (!cfg.match_uv || uv_ok) &&
                   (!cfg.match_normal || n_ok);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else begin
            hit_reg <= hit_next;
        end
        hit_idx_reg <= entry_idx;
    end

    // A hit in a lower cell has priority; otherwise offer our own.
    always_comb begin
        if (chain_in.found) begin
            chain_out = chain_in;
        end else if (hit_reg) begin
            chain_out.found = 1'b1;
            chain_out.index = hit_idx_reg;
        end else begin
            chain_out = chain_in;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/vertex_dedup_table.sv =====
// A clear request goes straight to the finish state; an add request first scans
// the table row by row, stopping early on a match; on an empty table no row is read.
// Either way the result is registered onto the output once the output is free.
// Throughput: one request at a time, set by the scan of 8 table cells per cycle,
// up to 128 rows; a new request is taken while the previous result waits.
// Reset: entry count cleared, match_uv and match_normal 0, tolerance 839;
// table contents are not cleared and only entries below the entry count can match.
`default_nettype none

module vertex_dedup_table (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Request channel.
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // vertex_id[15:0], tex_u[47:16], tex_v[79:48], normal_x[111:80],
    // normal_y[143:112], normal_z[175:144]
    input  wire logic [vdt_pkg::S_TDATA_W-1:0]  s_tdata,
    // mode[0]
    input  wire logic                           s_tuser,
    // Result channel.
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // entry_index[9:0], was_new[10], table_full[11], zero[15:12]
    output logic [vdt_pkg::M_TDATA_W-1:0]       m_tdata,
    // Configuration write port.
    input  wire logic                           cfg_wr_en,
    input  wire logic [vdt_pkg::CFG_ADDR_W-1:0] cfg_index,
    input  wire logic [vdt_pkg::TOL_W-1:0]      cfg_wdata
);

    vdt_pkg::state_t                 state_reg, state_next;
    logic [vdt_pkg::CNT_W-1:0]       count_reg, count_next;
    vdt_pkg::entry_t                 query_reg, query_next;
    logic [vdt_pkg::ROWCNT_W-1:0]    rd_row_reg, rd_row_next;
    logic [vdt_pkg::ROWCNT_W-1:0]    scan_rows_reg, scan_rows_next;
    logic                            rd_vld_reg, rd_vld_next;
    logic                            cmp_vld_reg, cmp_vld_next;
    logic [vdt_pkg::IDX_W-1:0]       res_idx_reg, res_idx_next;
    logic                            res_new_reg, res_new_next;
    logic                            res_full_reg, res_full_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [vdt_pkg::IDX_W-1:0]       m_idx_reg, m_idx_next;
    logic                            m_new_reg, m_new_next;
    logic                            m_full_reg, m_full_next;
    logic [vdt_pkg::CNT_W-1:0]       rows_round;
    logic                            issue;
    vdt_pkg::cfg_t                   cfg_reg;
    vdt_pkg::ctrl_t                  ctrl;
    vdt_pkg::chain_t                 chain [vdt_pkg::NUM_CELLS+1];

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.match_uv     <= 1'b0;
            cfg_reg.match_normal <= 1'b0;
            cfg_reg.tol          <= vdt_pkg::TOL_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                vdt_pkg::CFG_MATCH_UV:     cfg_reg.match_uv     <= cfg_wdata[0];
                vdt_pkg::CFG_MATCH_NORMAL: cfg_reg.match_normal <= cfg_wdata[0];
                vdt_pkg::CFG_TOLERANCE:    cfg_reg.tol          <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Row of cells; the first-hit token ripples from cell 0 upward.
    assign chain[0] = '0;

    for (genvar k = 0; k < vdt_pkg::NUM_CELLS; k++) begin : g_cell
        vdt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cell_idx  (vdt_pkg::CELL_W'(k)),
            .cfg       (cfg_reg),
            .ctrl      (ctrl),
            .query     (query_reg),
            .chain_in  (chain[k]),
            .chain_out (chain[k+1])
        );
    end

    // Sequencer: next state, scan control and result capture.
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        query_next     = query_reg;
        rd_row_next    = rd_row_reg;
        scan_rows_next = scan_rows_reg;
        rd_vld_next    = 1'b0;
        cmp_vld_next   = 1'b0;
        res_idx_next   = res_idx_reg;
        res_new_next   = res_new_reg;
        res_full_next  = res_full_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_idx_next     = m_idx_reg;
        m_new_next     = m_new_reg;
        m_full_next    = m_full_reg;
        s_tready       = 1'b0;

        rows_round   = vdt_pkg::CNT_W'(count_reg + vdt_pkg::CNT_W'(vdt_pkg::NUM_CELLS - 1));
        issue        = (rd_row_reg != scan_rows_reg);

        ctrl.rd_en   = 1'b0;
        ctrl.rd_row  = rd_row_reg[vdt_pkg::ROW_W-1:0];
        ctrl.rd_vld  = rd_vld_reg;
        ctrl.wr_en   = 1'b0;
        ctrl.wr_row  = count_reg[vdt_pkg::IDX_W-1:vdt_pkg::CELL_W];
        ctrl.wr_cell = count_reg[vdt_pkg::CELL_W-1:0];
        ctrl.count   = count_reg;

        case (state_reg)
            vdt_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser == vdt_pkg::MODE_CLEAR) begin
                        count_next    = '0;
                        res_idx_next  = '0;
                        res_new_next  = 1'b0;
                        res_full_next = 1'b0;
                        state_next    = vdt_pkg::ST_FINISH;
                    end else begin
                        query_next     = vdt_pkg::entry_t'(s_tdata);
                        rd_row_next    = '0;
                        scan_rows_next = rows_round[vdt_pkg::CNT_W-1:vdt_pkg::CELL_W];
                        state_next     = vdt_pkg::ST_SCAN;
                    end
                end
            end

            vdt_pkg::ST_SCAN: begin
                ctrl.rd_en   = issue;
                rd_vld_next  = issue;
                cmp_vld_next = rd_vld_reg;
                if (issue) begin
                    rd_row_next = rd_row_reg + 1'b1;
                end
                if (cmp_vld_reg && chain[vdt_pkg::NUM_CELLS].found) begin
                    // Lowest matching entry found.
                    res_idx_next  = chain[vdt_pkg::NUM_CELLS].index;
                    res_new_next  = 1'b0;
                    res_full_next = 1'b0;
                    rd_vld_next   = 1'b0;
                    cmp_vld_next  = 1'b0;
                    state_next    = vdt_pkg::ST_FINISH;
                end else if (!issue && !rd_vld_reg && !cmp_vld_reg) begin
                    // Scan exhausted with no match: append or report full.
                    if (count_reg == vdt_pkg::CNT_W'(vdt_pkg::TABLE_DEPTH)) begin
                        res_idx_next  = '0;
                        res_new_next  = 1'b0;
                        res_full_next = 1'b1;
                    end else begin
                        ctrl.wr_en    = 1'b1;
                        count_next    = count_reg + 1'b1;
                        res_idx_next  = count_reg[vdt_pkg::IDX_W-1:0];
                        res_new_next  = 1'b1;
                        res_full_next = 1'b0;
                    end
                    state_next = vdt_pkg::ST_FINISH;
                end
            end

            vdt_pkg::ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_idx_next    = res_idx_reg;
                    m_new_next    = res_new_reg;
                    m_full_next   = res_full_reg;
                    state_next    = vdt_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = vdt_pkg::ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vdt_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Control and datapath registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            cmp_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            rd_vld_reg   <= rd_vld_next;
            cmp_vld_reg  <= cmp_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        query_reg     <= query_next;
        rd_row_reg    <= rd_row_next;
        scan_rows_reg <= scan_rows_next;
        res_idx_reg   <= res_idx_next;
        res_new_reg   <= res_new_next;
        res_full_reg  <= res_full_next;
        m_idx_reg     <= m_idx_next;
        m_new_reg     <= m_new_next;
        m_full_reg    <= m_full_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = vdt_pkg::M_TDATA_W'({m_full_reg, m_new_reg, m_idx_reg});

endmodule

`default_nettype wire
